>>> hw/rtl/bpra_pkg.sv
// Shared types and constants for the bitmap page run allocator.
// No dependencies; imported by bitmap_page_run_allocator.
package bpra_pkg;

    localparam int WORD_BITS = 64;    // pages per bitmap word
    localparam int WORD_LOG  = 6;     // log2 of WORD_BITS
    localparam int PAGE_W    = 12;    // width of a page index field
    localparam int CNT_W     = 13;    // width of a page count field

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [PAGE_W-1:0] first_page;
        logic [CNT_W-1:0]  page_count;
    } bpra_in_t;

    typedef struct packed {
        logic              ok;
        logic [PAGE_W-1:0] start_page;
        logic [CNT_W-1:0]  free_pages;
    } bpra_out_t;

endpackage

>>> hw/rtl/bitmap_page_run_allocator.sv
// Bitmap page run allocator: next-fit run search over a used-page bitmap.
// Depends on bpra_pkg (payload structs, word geometry, command codes).
//
//   Channel   Ports                          Payload
//   input     s_valid, s_ready, s_data       bpra_in_t  {cmd, first_page, page_count}
//   result    m_valid, m_ready, m_data       bpra_out_t {ok, start_page, free_pages}
//
// The bitmap lives in one memory of 64-page words, with a registered read port.
// After reset an initialising pass writes every word to all ones, with s_ready low.
// Allocate: each word is read and checked in turn (from the search start to the top,
// then once more from page 0), then each word of the run is read and marked used.
// Free: each word touched is read and updated. A failed allocate on count goes to ST_RESP.
// One item at a time; the next item is taken while the last result waits in m_data.
module bitmap_page_run_allocator
    import bpra_pkg::*;
#(
    parameter int NUM_PAGES = 4096
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  bpra_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output bpra_out_t m_data
);

    localparam int NUM_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WAW       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int PW        = $clog2(NUM_PAGES);
    localparam int CW        = $clog2(NUM_PAGES + 1);
    localparam int XW        = (PW > CNT_W) ? PW : CNT_W;
    localparam int DW        = (CW > CNT_W) ? CW : CNT_W;

    localparam logic [XW-1:0]  PAGE_MAX  = XW'(NUM_PAGES - 1);
    localparam logic [WAW-1:0] LAST_WORD = WAW'(NUM_WORDS - 1);
    localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_RMW_RD,
        ST_RMW_WR,
        ST_RESP
    } state_t;

    function automatic logic [WORD_LOG:0] trail_ones(input logic [WORD_BITS-1:0] v);
        logic [WORD_LOG:0] c;
        c = (WORD_LOG + 1)'(WORD_BITS);
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!v[i]) begin
                c = (WORD_LOG + 1)'(i);
            end
        end
        return c;
    endfunction

    function automatic logic [WORD_LOG:0] lead_ones(input logic [WORD_BITS-1:0] v);
        logic [WORD_LOG:0] c;
        c = (WORD_LOG + 1)'(WORD_BITS);
        for (int i = 0; i < WORD_BITS; i++) begin
            if (!v[i]) begin
                c = (WORD_LOG + 1)'(WORD_BITS - 1 - i);
            end
        end
        return c;
    endfunction

    function automatic logic [WORD_LOG-1:0] low_index(input logic [WORD_BITS-1:0] v);
        logic [WORD_LOG-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = WORD_LOG'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [WORD_LOG:0] pop_count(input logic [WORD_BITS-1:0] v);
        logic [WORD_LOG:0] s;
        s = '0;
        for (int i = 0; i < WORD_BITS; i++) begin
            s = s + (WORD_LOG + 1)'(v[i]);
        end
        return s;
    endfunction

    // Bitmap storage
    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [WAW-1:0]       rd_addr;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    // Control and payload registers
    state_t               state_reg;
    logic [PW-1:0]        search_start_reg;
    logic [CW-1:0]        free_count_reg;
    logic [CW-1:0]        run_reg;
    logic [CNT_W-1:0]     n_reg;
    logic                 ok_reg;
    logic [XW-1:0]        start_reg;
    logic                 m_valid_reg;
    bpra_out_t            m_data_reg;

    logic [WAW-1:0]       iss_word_reg;
    logic                 iss_pass2_reg;
    logic                 iss_active_reg;
    logic                 pend_vld_reg;
    logic [WAW-1:0]       pend_word_reg;
    logic                 pend_first_reg;
    logic                 pend_pass2_reg;
    logic                 pend_final_reg;

    logic [WAW-1:0]       rmw_word_reg;
    logic [XW-1:0]        rmw_lo_reg;
    logic [XW-1:0]        rmw_last_reg;
    logic                 rmw_free_reg;

    // Request decode
    logic [XW-1:0]        req_lo;
    logic [XW:0]          req_end;
    logic [XW-1:0]        req_last;
    logic                 free_empty;
    logic                 alloc_ok;
    logic [WAW-1:0]       from_word;
    logic                 from_nz;

    // Scan datapath
    logic [XW-1:0]        scan_base;
    logic [WORD_BITS-1:0] free_vec;
    logic [CW-1:0]        run_in;
    logic [WORD_LOG:0]    tz;
    logic [WORD_LOG:0]    lz;
    logic                 cand1;
    logic                 cand2;
    logic [WORD_BITS-1:0] hv [WORD_LOG];
    logic [WORD_BITS-1:0] rvec;
    logic                 rset;
    logic                 hit;
    logic [XW-1:0]        hit_start;
    logic [CW-1:0]        run_next;
    logic                 scan_stop;

    // Read-modify-write datapath
    logic [WAW-1:0]       rmw_lo_word;
    logic [WAW-1:0]       rmw_last_word;
    logic [WORD_BITS-1:0] rmw_mask;
    logic [WORD_BITS-1:0] rmw_new;
    logic [CW-1:0]        rmw_gain;
    logic [DW-1:0]        fc_ext;
    logic                 resp_fire;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign fc_ext    = DW'(free_count_reg);
    assign resp_fire = (state_reg == ST_RESP) && (!m_valid_reg || m_ready);

    always_comb begin
        req_lo     = XW'(s_data.first_page);
        req_end    = (XW + 1)'(s_data.first_page) + (XW + 1)'(s_data.page_count)
                   - (XW + 1)'(1);
        req_last   = (req_end > (XW + 1)'(PAGE_MAX)) ? PAGE_MAX : req_end[XW-1:0];
        free_empty = (s_data.page_count == '0) || (req_lo > PAGE_MAX);
        alloc_ok   = (s_data.page_count != '0)
                  && (DW'(s_data.page_count) <= DW'(NUM_PAGES))
                  && (DW'(free_count_reg) >= DW'(s_data.page_count));
        from_word  = WAW'(XW'(search_start_reg) >> WORD_LOG);
        from_nz    = (search_start_reg != '0);
    end

    // One word of the next-fit scan: continue the run from the word below, or find
    // the lowest run that lies wholly inside this word.
    always_comb begin
        scan_base = XW'(pend_word_reg) << WORD_LOG;
        free_vec  = ~rd_data_reg;
        if (pend_first_reg && !pend_pass2_reg) begin
            free_vec = free_vec & (ONES << search_start_reg[WORD_LOG-1:0]);
        end
        run_in = pend_first_reg ? '0 : run_reg;
        tz     = trail_ones(free_vec);
        lz     = lead_ones(free_vec);
        cand1  = ((DW + 1)'(run_in) + (DW + 1)'(tz)) >= (DW + 1)'(n_reg);

        // hv[k] bit i: pages i .. i+2^k-1 of this word are all free
        hv[0] = free_vec;
        for (int k = 1; k < WORD_LOG; k++) begin
            hv[k] = hv[k-1] & (hv[k-1] >> (1 << (k - 1)));
        end
        // rvec bit i: a run of the low count bits of n_reg starts at i
        rvec = ONES;
        rset = 1'b0;
        for (int k = 0; k < WORD_LOG; k++) begin
            if (n_reg[k]) begin
                rvec = rset ? (hv[k] & (rvec >> (1 << k))) : hv[k];
                rset = 1'b1;
            end
        end
        cand2 = (n_reg[CNT_W-1:WORD_LOG] == '0) && (|rvec);

        hit       = cand1 || cand2;
        hit_start = cand1 ? (scan_base - XW'(run_in))
                          : (scan_base + XW'(low_index(rvec)));
        run_next  = (&free_vec) ? (run_in + CW'(WORD_BITS)) : CW'(lz);
        scan_stop = pend_vld_reg && (hit || pend_final_reg);
    end

    always_comb begin
        rmw_lo_word   = WAW'(rmw_lo_reg >> WORD_LOG);
        rmw_last_word = WAW'(rmw_last_reg >> WORD_LOG);
        rmw_mask      = ONES;
        if (rmw_word_reg == rmw_lo_word) begin
            rmw_mask = rmw_mask & (ONES << rmw_lo_reg[WORD_LOG-1:0]);
        end
        if (rmw_word_reg == rmw_last_word) begin
            rmw_mask = rmw_mask
                     & (ONES >> (WORD_LOG'(WORD_BITS - 1) - rmw_last_reg[WORD_LOG-1:0]));
        end
        rmw_new  = rmw_free_reg ? (rd_data_reg & ~rmw_mask) : (rd_data_reg | rmw_mask);
        rmw_gain = CW'(pop_count(rd_data_reg & rmw_mask));
    end

    always_comb begin
        rd_addr = (state_reg == ST_SCAN) ? iss_word_reg : rmw_word_reg;
        wr_en   = (state_reg == ST_INIT) || (state_reg == ST_RMW_WR);
        wr_data = (state_reg == ST_INIT) ? ONES : rmw_new;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[rmw_word_reg] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_INIT;
            rmw_word_reg     <= '0;
            search_start_reg <= '0;
            free_count_reg   <= '0;
            m_valid_reg      <= 1'b0;
            iss_active_reg   <= 1'b0;
            pend_vld_reg     <= 1'b0;
        end else begin
            if (resp_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT: begin
                    if (rmw_word_reg == LAST_WORD) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        rmw_word_reg <= rmw_word_reg + WAW'(1);
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        n_reg     <= s_data.page_count;
                        start_reg <= '0;
                        if (s_data.cmd == CMD_FREE) begin
                            ok_reg <= 1'b1;
                            if (free_empty) begin
                                state_reg <= ST_RESP;
                            end else begin
                                rmw_lo_reg   <= req_lo;
                                rmw_last_reg <= req_last;
                                rmw_word_reg <= WAW'(req_lo >> WORD_LOG);
                                rmw_free_reg <= 1'b1;
                                state_reg    <= ST_RMW_RD;
                            end
                        end else begin
                            ok_reg <= 1'b0;
                            if (alloc_ok) begin
                                iss_word_reg   <= from_word;
                                iss_pass2_reg  <= 1'b0;
                                iss_active_reg <= 1'b1;
                                pend_vld_reg   <= 1'b0;
                                state_reg      <= ST_SCAN;
                            end else begin
                                state_reg <= ST_RESP;
                            end
                        end
                    end
                end
                ST_SCAN: begin
                    // issue side: one word read per cycle, tagged for the check stage
                    pend_word_reg  <= iss_word_reg;
                    pend_pass2_reg <= iss_pass2_reg;
                    pend_first_reg <= iss_pass2_reg ? (iss_word_reg == '0)
                                                    : (iss_word_reg == from_word);
                    pend_final_reg <= (iss_word_reg == LAST_WORD)
                                   && (iss_pass2_reg || !from_nz);
                    if (scan_stop) begin
                        // drop the read in flight once the scan ends
                        iss_active_reg <= 1'b0;
                        pend_vld_reg   <= 1'b0;
                    end else begin
                        pend_vld_reg <= iss_active_reg;
                        if (iss_active_reg) begin
                            if (iss_word_reg == LAST_WORD) begin
                                if (!iss_pass2_reg && from_nz) begin
                                    iss_word_reg  <= '0;
                                    iss_pass2_reg <= 1'b1;
                                end else begin
                                    iss_active_reg <= 1'b0;
                                end
                            end else begin
                                iss_word_reg <= iss_word_reg + WAW'(1);
                            end
                        end
                    end
                    // check side
                    if (pend_vld_reg) begin
                        if (hit) begin
                            ok_reg           <= 1'b1;
                            start_reg        <= hit_start;
                            search_start_reg <= PW'(hit_start);
                            free_count_reg   <= free_count_reg - CW'(n_reg);
                            rmw_lo_reg       <= hit_start;
                            rmw_last_reg     <= hit_start + XW'(n_reg) - XW'(1);
                            rmw_word_reg     <= WAW'(hit_start >> WORD_LOG);
                            rmw_free_reg     <= 1'b0;
                            state_reg        <= ST_RMW_RD;
                        end else if (pend_final_reg) begin
                            state_reg <= ST_RESP;
                        end else begin
                            run_reg <= run_next;
                        end
                    end
                end
                ST_RMW_RD: begin
                    state_reg <= ST_RMW_WR;
                end
                ST_RMW_WR: begin
                    if (rmw_free_reg) begin
                        free_count_reg <= free_count_reg + rmw_gain;
                    end
                    if (rmw_word_reg == rmw_last_word) begin
                        state_reg <= ST_RESP;
                    end else begin
                        rmw_word_reg <= rmw_word_reg + WAW'(1);
                        state_reg    <= ST_RMW_RD;
                    end
                end
                ST_RESP: begin
                    // hold until the output register is free
                    if (resp_fire) begin
                        m_data_reg.ok         <= ok_reg;
                        m_data_reg.start_page <= start_reg[PAGE_W-1:0];
                        m_data_reg.free_pages <= fc_ext[CNT_W-1:0];
                        state_reg             <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_free_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        DW'(free_count_reg) <= DW'(NUM_PAGES))
        else $error("free count exceeds the number of pages");

    a_search_start_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        XW'(search_start_reg) <= PAGE_MAX)
        else $error("search start outside the map");

    a_pend_only_in_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SCAN) |-> (!pend_vld_reg && !iss_active_reg))
        else $error("scan read in flight outside a search");

    a_mark_after_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && pend_vld_reg && hit) |=>
            (state_reg == ST_RMW_RD && ok_reg && !rmw_free_reg))
        else $error("run found but not marked used");

    a_mark_within_map: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RMW_WR) |-> (rmw_last_reg <= PAGE_MAX && rmw_lo_reg <= rmw_last_reg))
        else $error("update range leaves the map");

endmodule
